// File: rtl/core/mpct_pkg.sv
// package of types and constants for the mouse packet cursor tracker
package mpct_pkg;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE        = 2'd0,
        REG_SCREEN_WIDTH  = 2'd1,
        REG_SCREEN_HEIGHT = 2'd2
    } cfg_reg_t;

    // payload widths
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned CURSOR_W = 10;
    localparam int unsigned BUTTON_W = 3;

    // header byte layout
    localparam logic [DATA_W-1:0]   SYNC_BIT    = 8'h08;
    localparam logic [BUTTON_W-1:0] BUTTON_MASK = 3'h7;

    // size registers after reset
    localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 11'd320;
    localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 11'd200;

    // position within a three-byte packet
    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2
    } byte_pos_t;

endpackage

// File: rtl/core/mouse_packet_cursor_tracker_core.sv
// mouse packet decoder and clamped cursor tracker, top level
// Each accepted byte gives exactly one result transaction in the next cycle,
// carrying the cursor, the buttons and a packet-complete flag.
// Bytes are taken at one per cycle for as long as the result side keeps up;
// the single output register sets that figure, and s_ready drops only while
// a result is held there and m_ready is low. A header byte needs bit 3 set to
// start a packet, the next two bytes are the X and Y deltas, and the cursor
// moves and is clamped to the screen size when the Y byte arrives. Writes to
// the configuration port take effect at once and belong to idle periods;
// a size change does not move the held cursor until the next packet.
module mouse_packet_cursor_tracker_core #(
    parameter int unsigned COORD_BITS = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [mpct_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mpct_pkg::CFG_DATA_W-1:0]       cfg_wr_data,

    // byte stream in
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [mpct_pkg::DATA_W-1:0]           s_data_byte,

    // result stream out
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mpct_pkg::CURSOR_W-1:0]         m_cursor_x,
    output logic [mpct_pkg::CURSOR_W-1:0]         m_cursor_y,
    output logic [mpct_pkg::BUTTON_W-1:0]         m_button_bits,
    output logic                                  m_packet_complete
);

    // signed width holding position plus or minus an 8-bit delta
    localparam int unsigned SUM_W  = COORD_BITS + 2;
    // width for comparing sizes against the coordinate range
    localparam int unsigned SIZE_W = (COORD_BITS + 1 > mpct_pkg::CFG_DATA_W) ?
                                     COORD_BITS + 1 : mpct_pkg::CFG_DATA_W;
    localparam logic [SIZE_W-1:0]     TOP_LIMIT   = SIZE_W'(1) << COORD_BITS;
    localparam logic [COORD_BITS-1:0] RESET_POS_X =
        COORD_BITS'(mpct_pkg::RESET_WIDTH >> 1);
    localparam logic [COORD_BITS-1:0] RESET_POS_Y =
        COORD_BITS'(mpct_pkg::RESET_HEIGHT >> 1);

    // configuration registers
    logic                              enable_reg;
    logic [mpct_pkg::CFG_DATA_W-1:0]   screen_width_reg;
    logic [mpct_pkg::CFG_DATA_W-1:0]   screen_height_reg;

    // packet assembly and cursor state
    mpct_pkg::byte_pos_t               byte_pos_reg, byte_pos_next;
    logic [mpct_pkg::DATA_W-1:0]       header_reg, header_next;
    logic [mpct_pkg::DATA_W-1:0]       x_delta_reg, x_delta_next;
    logic [COORD_BITS-1:0]             pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0]             pos_y_reg, pos_y_next;
    logic [mpct_pkg::BUTTON_W-1:0]     buttons_reg, buttons_next;
    logic                              done_next;

    // output register
    logic                              m_valid_reg;
    logic [mpct_pkg::CURSOR_W-1:0]     m_cursor_x_reg;
    logic [mpct_pkg::CURSOR_W-1:0]     m_cursor_y_reg;
    logic [mpct_pkg::BUTTON_W-1:0]     m_button_bits_reg;
    logic                              m_packet_complete_reg;

    logic                              in_accept;
    logic [SIZE_W-1:0]                 limit_x, limit_y;
    logic signed [SUM_W-1:0]           sum_x, sum_y;
    logic [COORD_BITS-1:0]             clamp_x, clamp_y;

    // a zero size acts as one, an oversize one as the full coordinate range
    function automatic logic [SIZE_W-1:0] eff_limit(
        input logic [mpct_pkg::CFG_DATA_W-1:0] size
    );
        logic [SIZE_W-1:0] wide;
        wide = SIZE_W'(size);
        if (wide == '0) begin
            return SIZE_W'(1);
        end else if (wide > TOP_LIMIT) begin
            return TOP_LIMIT;
        end
        return wide;
    endfunction

    // clamp a signed coordinate to 0..limit-1
    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [SUM_W-1:0] v,
        input logic [SIZE_W-1:0]       limit
    );
        logic [SIZE_W-1:0] mag;
        logic [SIZE_W-1:0] top;
        mag = SIZE_W'(v[SUM_W-2:0]);
        top = limit - SIZE_W'(1);
        if (v[SUM_W-1]) begin
            return '0;
        end else if (mag >= limit) begin
            return top[COORD_BITS-1:0];
        end
        return mag[COORD_BITS-1:0];
    endfunction

    // take a byte whenever the output register is free or being emptied
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    // candidate positions, used only on the Y byte
    assign limit_x = eff_limit(screen_width_reg);
    assign limit_y = eff_limit(screen_height_reg);
    assign sum_x   = $signed({2'b00, pos_x_reg}) + SUM_W'($signed(x_delta_reg));
    assign sum_y   = $signed({2'b00, pos_y_reg}) - SUM_W'($signed(s_data_byte));
    assign clamp_x = clamp_coord(sum_x, limit_x);
    assign clamp_y = clamp_coord(sum_y, limit_y);

    // packet assembly: next state from the current byte
    always_comb begin
        byte_pos_next = byte_pos_reg;
        header_next   = header_reg;
        x_delta_next  = x_delta_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        buttons_next  = buttons_reg;
        done_next     = 1'b0;
        if (enable_reg) begin
            unique case (byte_pos_reg)
                mpct_pkg::POS_X: begin
                    x_delta_next  = s_data_byte;
                    byte_pos_next = mpct_pkg::POS_Y;
                end
                mpct_pkg::POS_Y: begin
                    pos_x_next    = clamp_x;
                    pos_y_next    = clamp_y;
                    buttons_next  = header_reg[mpct_pkg::BUTTON_W-1:0] &
                                    mpct_pkg::BUTTON_MASK;
                    byte_pos_next = mpct_pkg::POS_HEADER;
                    done_next     = 1'b1;
                end
                default: begin
                    // header slot, also the unused position code
                    byte_pos_next = mpct_pkg::POS_HEADER;
                    if ((s_data_byte & mpct_pkg::SYNC_BIT) != '0) begin
                        header_next   = s_data_byte;
                        byte_pos_next = mpct_pkg::POS_X;
                    end
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg        <= 1'b0;
            screen_width_reg  <= mpct_pkg::RESET_WIDTH;
            screen_height_reg <= mpct_pkg::RESET_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mpct_pkg::REG_ENABLE:        enable_reg        <= cfg_wr_data[0];
                mpct_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wr_data;
                mpct_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // packet and cursor state, moved only by accepted bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg <= mpct_pkg::POS_HEADER;
            header_reg   <= '0;
            x_delta_reg  <= '0;
            pos_x_reg    <= RESET_POS_X;
            pos_y_reg    <= RESET_POS_Y;
            buttons_reg  <= '0;
        end else if (in_accept) begin
            byte_pos_reg <= byte_pos_next;
            header_reg   <= header_next;
            x_delta_reg  <= x_delta_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            buttons_reg  <= buttons_next;
        end
    end

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output payload, loaded with the state after this byte
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_cursor_x_reg        <= mpct_pkg::CURSOR_W'(pos_x_next);
            m_cursor_y_reg        <= mpct_pkg::CURSOR_W'(pos_y_next);
            m_button_bits_reg     <= buttons_next;
            m_packet_complete_reg <= done_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cursor_x        = m_cursor_x_reg;
    assign m_cursor_y        = m_cursor_y_reg;
    assign m_button_bits     = m_button_bits_reg;
    assign m_packet_complete = m_packet_complete_reg;

    // a held result always mirrors the live cursor state
    a_result_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_cursor_x_reg == mpct_pkg::CURSOR_W'(pos_x_reg)) &&
                        (m_cursor_y_reg == mpct_pkg::CURSOR_W'(pos_y_reg)) &&
                        (m_button_bits_reg == buttons_reg))
        else $error("held result differs from cursor state");

    // a disabled block leaves packet state untouched
    a_disabled_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !enable_reg) |=> $stable(byte_pos_reg) &&
                                      $stable(pos_x_reg) && $stable(pos_y_reg))
        else $error("state moved while disabled");

    // the Y byte closes the packet and flags it
    a_y_byte_completes: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && enable_reg && byte_pos_reg == mpct_pkg::POS_Y) |=>
            (byte_pos_reg == mpct_pkg::POS_HEADER) && m_packet_complete_reg)
        else $error("packet not completed on Y byte");

    // the cursor only moves with a completed packet
    a_move_needs_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !done_next) |=> $stable(pos_x_reg) && $stable(pos_y_reg) &&
                                      !m_packet_complete_reg)
        else $error("cursor moved without a completed packet");

endmodule
